[rtl/fpart_pkg.sv]
// Shared types and constants for the four-way partition block.
// No dependencies; used by fpart_ctrl and four_way_partition.
package fpart_pkg;

  localparam int unsigned RES_BITS = 16;

  typedef enum logic [1:0] {
    KIND_FRONT = 2'd0,
    KIND_KEEP  = 2'd1,
    KIND_UPPER = 2'd2,
    KIND_TOP   = 2'd3
  } elem_kind_t;

  typedef struct packed {
    logic strobe;
    logic last;
  } emit_t;

endpackage

[rtl/fpart_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module fpart_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/fpart_ctrl.sv]
// Load, partition and emit sequencer for the four-way partition block.
// Drives the element RAM (fpart_ram); uses fpart_pkg for kinds and emit word.
module fpart_ctrl #(
  parameter int unsigned MAX_ITEMS  = 64,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [VALUE_BITS-1:0]       in_value,
  input  logic                        in_last,
  output logic                        busy,
  output logic                        ram_we,
  output logic [((MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1)-1:0] ram_waddr,
  output logic [VALUE_BITS-1:0]       ram_wdata,
  output logic [((MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1)-1:0] ram_raddr,
  input  logic [VALUE_BITS-1:0]       ram_rdata,
  output fpart_pkg::emit_t            emit
);
  import fpart_pkg::*;

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOP,
    ST_EVAL,
    ST_FETCH2,
    ST_WR_S,
    ST_WR_P,
    ST_WR_T,
    ST_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   low_r, low_nxt;
  logic [CW-1:0]   scan_r, scan_nxt;
  logic [CW-1:0]   upper_r, upper_nxt;
  logic [CW-1:0]   top_r, top_nxt;
  logic [CW-1:0]   eidx_r, eidx_nxt;
  logic [AW-1:0]   sa_r, sa_nxt;
  logic [AW-1:0]   pa_r, pa_nxt;
  logic [AW-1:0]   ta_r, ta_nxt;
  elem_kind_t      kind_r, kind_nxt;
  logic [VALUE_BITS-1:0] a_r, a_nxt;
  logic [VALUE_BITS-1:0] b_r, b_nxt;
  logic [VALUE_BITS-1:0] c_r, c_nxt;
  emit_t           emit_r, emit_nxt;
  logic [CW-1:0]   cnt_inc;
  logic [CW-1:0]   upper_dec;
  logic [CW-1:0]   top_dec;
  elem_kind_t      kind_now;

  assign cnt_inc   = count_r + CW'(1);
  assign upper_dec = upper_r - CW'(1);
  assign top_dec   = top_r - CW'(1);
  assign kind_now  = elem_kind_t'(ram_rdata[1:0]);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    low_nxt   = low_r;
    scan_nxt  = scan_r;
    upper_nxt = upper_r;
    top_nxt   = top_r;
    eidx_nxt  = eidx_r;
    sa_nxt    = sa_r;
    pa_nxt    = pa_r;
    ta_nxt    = ta_r;
    kind_nxt  = kind_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    emit_nxt  = '0;
    ram_we    = 1'b0;
    ram_waddr = sa_r;
    ram_wdata = a_r;
    ram_raddr = scan_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          ram_we    = 1'b1;
          ram_waddr = count_r[AW-1:0];
          ram_wdata = in_value;
          count_nxt = cnt_inc;
          if (in_last || cnt_inc == CW'(MAX_ITEMS)) begin
            state_nxt = ST_LOOP;
            low_nxt   = '0;
            scan_nxt  = '0;
            upper_nxt = cnt_inc;
            top_nxt   = cnt_inc;
          end
        end
      end
      ST_LOOP: begin
        ram_raddr = scan_r[AW-1:0];
        if (scan_r < upper_r) begin
          sa_nxt    = scan_r[AW-1:0];
          state_nxt = ST_EVAL;
        end else begin
          eidx_nxt  = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EVAL: begin
        a_nxt    = ram_rdata;
        kind_nxt = kind_now;
        unique case (kind_now)
          KIND_FRONT: begin
            ram_raddr = low_r[AW-1:0];
            pa_nxt    = low_r[AW-1:0];
            low_nxt   = low_r + CW'(1);
            scan_nxt  = scan_r + CW'(1);
            state_nxt = ST_WR_S;
          end
          KIND_KEEP: begin
            scan_nxt  = scan_r + CW'(1);
            state_nxt = ST_LOOP;
          end
          KIND_UPPER: begin
            ram_raddr = upper_dec[AW-1:0];
            pa_nxt    = upper_dec[AW-1:0];
            upper_nxt = upper_dec;
            state_nxt = ST_WR_S;
          end
          KIND_TOP: begin
            ram_raddr = upper_dec[AW-1:0];
            pa_nxt    = upper_dec[AW-1:0];
            ta_nxt    = top_dec[AW-1:0];
            upper_nxt = upper_dec;
            top_nxt   = top_dec;
            state_nxt = ST_FETCH2;
          end
          default: begin
            state_nxt = ST_LOOP;
          end
        endcase
      end
      ST_FETCH2: begin
        b_nxt     = ram_rdata;
        ram_raddr = ta_r;
        state_nxt = ST_WR_S;
      end
      ST_WR_S: begin
        ram_we    = 1'b1;
        ram_waddr = sa_r;
        ram_wdata = (kind_r == KIND_TOP) ? b_r : ram_rdata;
        c_nxt     = ram_rdata;
        state_nxt = ST_WR_P;
      end
      ST_WR_P: begin
        ram_we    = 1'b1;
        ram_waddr = pa_r;
        ram_wdata = (kind_r == KIND_TOP) ? c_r : a_r;
        state_nxt = (kind_r == KIND_TOP) ? ST_WR_T : ST_LOOP;
      end
      ST_WR_T: begin
        ram_we    = 1'b1;
        ram_waddr = ta_r;
        ram_wdata = a_r;
        state_nxt = ST_LOOP;
      end
      ST_EMIT: begin
        ram_raddr       = eidx_r[AW-1:0];
        emit_nxt.strobe = 1'b1;
        emit_nxt.last   = (eidx_r + CW'(1) == count_r);
        eidx_nxt        = eidx_r + CW'(1);
        if (eidx_r + CW'(1) == count_r) begin
          state_nxt = ST_IDLE;
          count_nxt = '0;
          low_nxt   = '0;
          scan_nxt  = '0;
          upper_nxt = '0;
          top_nxt   = '0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      low_r   <= '0;
      scan_r  <= '0;
      upper_r <= '0;
      top_r   <= '0;
      eidx_r  <= '0;
      emit_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      low_r   <= low_nxt;
      scan_r  <= scan_nxt;
      upper_r <= upper_nxt;
      top_r   <= top_nxt;
      eidx_r  <= eidx_nxt;
      emit_r  <= emit_nxt;
    end
    sa_r   <= sa_nxt;
    pa_r   <= pa_nxt;
    ta_r   <= ta_nxt;
    kind_r <= kind_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
  end

  assign busy = (state_r != ST_IDLE);
  assign emit = emit_r;

endmodule

[rtl/four_way_partition.sv]
// Four-way partition top level: element RAM, sequencer and result register.
// Depends on fpart_pkg, fpart_ram and fpart_ctrl.
//
// A block is loaded one word per cycle (start high, busy low); the word with
// in_last set, or the word that fills MAX_ITEMS entries, starts the partition
// and raises busy. Each element then takes one scan pass on the single RAM:
// a read and an evaluation for class 1, plus one extra read and two writes
// for class 0 and class 2, plus two extra reads and three writes for class 3.
// The block is then emitted in stored order at one word per cycle, through the
// RAM read register and the result register, with out_last_res on its final
// word; busy drops in the cycle after the last read is issued. Results are
// shown for one cycle on out_strobe and cannot be held off. Entries are never
// cleared; only data from loaded entries is ever used.
module four_way_partition #(
  parameter int unsigned MAX_ITEMS  = 64,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [VALUE_BITS-1:0]           in_value,
  input  logic                            in_last,
  output logic                            out_strobe,
  output logic [fpart_pkg::RES_BITS-1:0]  out_value_res,
  output logic                            out_last_res
);
  import fpart_pkg::*;

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;
  emit_t                 emit;
  logic                  out_strobe_r;
  logic                  out_last_r;
  logic [RES_BITS-1:0]   out_value_r;

  fpart_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ITEMS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fpart_ctrl #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_value  (in_value),
    .in_last   (in_last),
    .busy      (busy),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .emit      (emit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      out_strobe_r <= emit.strobe;
      out_last_r   <= emit.strobe & emit.last;
    end
    out_value_r <= RES_BITS'(ram_rdata);
  end

  assign out_strobe    = out_strobe_r;
  assign out_value_res = out_value_r;
  assign out_last_res  = out_last_r;

  a_last_has_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_res |-> out_strobe)
    else $error("last marker without result strobe");

  a_gap_after_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_res) |=> !out_strobe)
    else $error("result word directly after end of block");

  a_last_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last) |=> busy)
    else $error("final word did not start the partition");

  a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy, 2))
    else $error("result word without an emit read");

endmodule

[sim/four_way_partition_tb.sv]
// Self-checking testbench for four_way_partition: loads blocks through the start/busy port,
// predicts the class-ordered block in a scoreboard class and checks every result word.
// Depends on fpart_pkg and the four_way_partition RTL.
module four_way_partition_tb;
  import fpart_pkg::*;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned WBITS       = 16;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic [RES_BITS-1:0] value;
    logic                last;
  } out_word_t;

  class flag_order_checker;
    logic [WBITS-1:0] block_mem [DEPTH];
    int unsigned      fill;
    out_word_t        due [$];
    int unsigned      mismatches;

    function void swap_entries(int unsigned p, int unsigned q);
      logic [WBITS-1:0] t;
      if (p >= DEPTH || q >= DEPTH) return;
      t = block_mem[p];
      block_mem[p] = block_mem[q];
      block_mem[q] = t;
    endfunction

    function void partition_by_class();
      int unsigned lo;
      int unsigned scan;
      int unsigned up;
      int unsigned top;
      elem_kind_t  kind;
      lo = 0;
      scan = 0;
      up = fill;
      top = fill;
      while (scan < up && scan < DEPTH) begin
        kind = elem_kind_t'(block_mem[scan][1:0]);
        case (kind)
          KIND_FRONT: begin
            swap_entries(lo, scan);
            lo++;
            scan++;
          end
          KIND_KEEP: begin
            scan++;
          end
          KIND_UPPER: begin
            up--;
            swap_entries(scan, up);
          end
          default: begin
            up--;
            top--;
            swap_entries(scan, up);
            swap_entries(up, top);
          end
        endcase
      end
    endfunction

    function void note_input(logic [WBITS-1:0] value, logic last);
      out_word_t w;
      if (fill >= DEPTH) fill = DEPTH - 1;
      block_mem[fill] = value;
      fill++;
      if (!last && fill < DEPTH) return;
      partition_by_class();
      for (int unsigned n = 0; n < fill; n++) begin
        w.value = block_mem[n];
        w.last  = (n + 1 == fill);
        due.push_back(w);
      end
      fill = 0;
    endfunction

    function void check_output(logic [RES_BITS-1:0] value, logic last);
      out_word_t w;
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected word: value=%h last=%b", value, last);
        return;
      end
      w = due.pop_front();
      if (value !== w.value || last !== w.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("word mismatch: expected value=%h last=%b, got value=%h last=%b",
                   w.value, w.last, value, last);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [WBITS-1:0]    in_value = '0;
  logic                in_last = 1'b0;
  logic                out_strobe;
  logic [RES_BITS-1:0] out_value_res;
  logic                out_last_res;

  flag_order_checker scoreboard = new();
  int unsigned       gap_pct = 0;
  int unsigned       words_sent = 0;
  int unsigned       cycles = 0;

  four_way_partition #(
    .MAX_ITEMS  (DEPTH),
    .VALUE_BITS (WBITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .in_last       (in_last),
    .out_strobe    (out_strobe),
    .out_value_res (out_value_res),
    .out_last_res  (out_last_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) scoreboard.check_output(out_value_res, out_last_res);
  end

  task automatic pause_sender();
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_word(logic [WBITS-1:0] value, logic last);
    pause_sender();
    start    <= 1'b1;
    in_value <= value;
    in_last  <= last;
    do @(posedge clk); while (busy);
    scoreboard.note_input(value, last);
    words_sent++;
  endtask

  // cls < 0 draws each class at random; otherwise force every word into one class
  task automatic send_block(int unsigned len, int cls, bit mark_last);
    logic [WBITS-1:0] v;
    for (int unsigned n = 0; n < len; n++) begin
      v = WBITS'($urandom);
      if (cls >= 0) v[1:0] = cls[1:0];
      send_word(v, mark_last && (n + 1 == len));
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (scoreboard.due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned pct [3];
    int unsigned target;
    int          cls;
    pct[0] = 0;
    pct[1] = 77;
    pct[2] = 16;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(16'h0000, 1'b1);
    send_word(16'hFFFF, 1'b1);
    send_word(16'h0003, 1'b0);
    send_word(16'hFFFE, 1'b0);
    send_word(16'h8001, 1'b0);
    send_word(16'h7FFC, 1'b0);
    send_word(16'hAAAB, 1'b0);
    send_word(16'h5556, 1'b0);
    send_word(16'hFFFD, 1'b0);
    send_word(16'h8000, 1'b1);
    send_block(4, 3, 1'b1);
    send_word(16'h0002, 1'b0);
    send_word(16'h0004, 1'b1);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = pct[phase];
      target = words_sent + ((phase < 2) ? 95 : 80);
      if (phase == 0) send_block(DEPTH, -1, 1'b1);
      if (phase == 1) send_block(DEPTH, -1, 1'b0);
      while (words_sent < target) begin
        cls = ($urandom_range(3) == 0) ? int'($urandom_range(3)) : -1;
        send_block($urandom_range(1, 16), cls, 1'b1);
      end
      drain();
    end

    if (scoreboard.mismatches == 0 && scoreboard.due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/fpart_pkg.sv
rtl/fpart_ram.sv
rtl/fpart_ctrl.sv
rtl/four_way_partition.sv
sim/four_way_partition_tb.sv
